FILE: design/mlr_pkg.sv
// Package for the midpoint line rasterizer: widths, types, register indexes
// and small helper functions shared by the interfaces and all modules.
// Depends on nothing.
package mlr_pkg;

    localparam int COORD_BITS     = 12;
    localparam int SIZE_BITS      = 12;
    localparam int COLOR_BITS     = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int EXT_BITS       = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
    localparam int ERR_BITS       = 2 * COORD_BITS + 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   diff_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic signed [EXT_BITS-1:0]   ext_t;
    typedef logic [SIZE_BITS-1:0]         size_t;
    typedef logic [COLOR_BITS-1:0]        color_t;
    typedef logic [CFG_INDEX_BITS-1:0]    cfg_index_t;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    localparam cfg_index_t CFG_IMAGE_WIDTH  = cfg_index_t'(0);
    localparam cfg_index_t CFG_IMAGE_HEIGHT = cfg_index_t'(1);

    localparam size_t WIDTH_RESET  = size_t'(640);
    localparam size_t HEIGHT_RESET = size_t'(480);

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef struct packed {
        logic   active;
        logic   steep;
        diff_t  dx;
        diff_t  dy;
        coord_t final_major;
        coord_t cur_x;
        coord_t cur_y;
        err_t   err;
        color_t color;
    } line_state_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   visible;
        color_t color;
        logic   last;
    } pixel_t;

    function automatic ext_t coord_to_ext(coord_t v);
        return ext_t'(v);
    endfunction

    function automatic ext_t size_to_ext(size_t s);
        return ext_t'(s);
    endfunction

endpackage

FILE: design/mlr_line_if.sv
// Channel interfaces of the midpoint line rasterizer: line commands in,
// pixels out, and the configuration write channel.
// Depends on mlr_pkg.
interface mlr_line_if;
    logic                valid;
    logic                ready;
    logic                mode;
    mlr_pkg::coord_t     start_x;
    mlr_pkg::coord_t     start_y;
    mlr_pkg::coord_t     end_x;
    mlr_pkg::coord_t     end_y;
    mlr_pkg::color_t     pen_color;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, pen_color,
                    input ready);
    modport sink (input valid, mode, start_x, start_y, end_x, end_y, pen_color,
                  output ready);
endinterface

interface mlr_pixel_if;
    logic                valid;
    logic                ready;
    mlr_pkg::coord_t     pixel_x;
    mlr_pkg::coord_t     pixel_y;
    logic                visible;
    mlr_pkg::color_t     pixel_color;
    logic                last_pixel;

    modport source (output valid, pixel_x, pixel_y, visible, pixel_color, last_pixel,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, visible, pixel_color, last_pixel,
                  output ready);
endinterface

interface mlr_cfg_if;
    logic                  valid;
    logic                  ready;
    mlr_pkg::cfg_index_t   index;
    mlr_pkg::size_t        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/mlr_load_unit.sv
// Line setup: picks the major axis, orders the endpoints along it and forms
// the starting midpoint decision value. Purely combinational.
// Depends on mlr_pkg.
module mlr_load_unit (
    input  mlr_pkg::coord_t      start_x,
    input  mlr_pkg::coord_t      start_y,
    input  mlr_pkg::coord_t      end_x,
    input  mlr_pkg::coord_t      end_y,
    input  mlr_pkg::color_t      pen_color,
    output mlr_pkg::line_state_t line_init
);

    mlr_pkg::diff_t  dx_raw;
    mlr_pkg::diff_t  dy_raw;
    mlr_pkg::diff_t  abs_dx;
    mlr_pkg::diff_t  abs_dy;
    mlr_pkg::diff_t  dx;
    mlr_pkg::diff_t  dy;
    mlr_pkg::coord_t first_x;
    mlr_pkg::coord_t first_y;
    mlr_pkg::coord_t final_x;
    mlr_pkg::coord_t final_y;
    logic            steep;
    logic            swap;

    always_comb
    begin
        dx_raw = mlr_pkg::diff_t'(end_x) - mlr_pkg::diff_t'(start_x);
        dy_raw = mlr_pkg::diff_t'(end_y) - mlr_pkg::diff_t'(start_y);
        abs_dx = dx_raw[mlr_pkg::COORD_BITS] ? -dx_raw : dx_raw;
        abs_dy = dy_raw[mlr_pkg::COORD_BITS] ? -dy_raw : dy_raw;
        steep  = abs_dy > abs_dx;
        swap   = steep ? (start_y > end_y) : (start_x > end_x);

        first_x = swap ? end_x : start_x;
        first_y = swap ? end_y : start_y;
        final_x = swap ? start_x : end_x;
        final_y = swap ? start_y : end_y;
        dx      = swap ? -dx_raw : dx_raw;
        dy      = swap ? -dy_raw : dy_raw;

        line_init.active      = 1'b1;
        line_init.steep       = steep;
        line_init.dx          = dx;
        line_init.dy          = dy;
        line_init.final_major = steep ? final_y : final_x;
        line_init.cur_x       = first_x;
        line_init.cur_y       = first_y;
        line_init.color       = pen_color;
        // The line passes through the first endpoint, so only the midpoint
        // offset terms of the doubled implicit function remain.
        if (steep)
        begin
            line_init.err = (mlr_pkg::err_t'(dx) <<< 1) - mlr_pkg::err_t'(dy);
        end
        else
        begin
            line_init.err = mlr_pkg::err_t'(dx) - (mlr_pkg::err_t'(dy) <<< 1);
        end
    end

endmodule

FILE: design/mlr_step_unit.sv
// Pixel step: forms the current pixel and advances the line by one unit on
// the major axis with the clamped midpoint test. Purely combinational.
// Depends on mlr_pkg.
module mlr_step_unit (
    input  mlr_pkg::line_state_t line_cur,
    input  mlr_pkg::size_t       image_width,
    input  mlr_pkg::size_t       image_height,
    output mlr_pkg::line_state_t line_next,
    output mlr_pkg::pixel_t      pixel
);

    mlr_pkg::ext_t x_ext;
    mlr_pkg::ext_t y_ext;
    mlr_pkg::ext_t w_ext;
    mlr_pkg::ext_t h_ext;
    logic          last;
    logic          minor_up;
    logic          minor_down;
    logic          minor_wrap;
    logic          err_neg;
    logic          err_pos;
    mlr_pkg::err_t dx2;
    mlr_pkg::err_t dy2;
    mlr_pkg::err_t err_step;

    always_comb
    begin
        x_ext = mlr_pkg::coord_to_ext(line_cur.cur_x);
        y_ext = mlr_pkg::coord_to_ext(line_cur.cur_y);
        w_ext = mlr_pkg::size_to_ext(image_width);
        h_ext = mlr_pkg::size_to_ext(image_height);

        last = line_cur.steep ? (line_cur.cur_y == line_cur.final_major)
                              : (line_cur.cur_x == line_cur.final_major);

        pixel.x       = line_cur.cur_x;
        pixel.y       = line_cur.cur_y;
        pixel.visible = (x_ext >= mlr_pkg::ext_t'(0)) && (x_ext < w_ext) &&
                        (y_ext >= mlr_pkg::ext_t'(0)) && (y_ext < h_ext);
        pixel.color   = line_cur.color;
        pixel.last    = last;

        err_neg = line_cur.err < mlr_pkg::err_t'(0);
        err_pos = line_cur.err > mlr_pkg::err_t'(0);
        dx2     = mlr_pkg::err_t'(line_cur.dx) <<< 1;
        dy2     = mlr_pkg::err_t'(line_cur.dy) <<< 1;

        line_next = line_cur;
        line_next.active = !last;

        if (line_cur.steep)
        begin
            minor_up   = (line_cur.dx > mlr_pkg::diff_t'(0)) && err_pos &&
                         (x_ext < w_ext - mlr_pkg::ext_t'(1));
            minor_down = (line_cur.dx < mlr_pkg::diff_t'(0)) && err_neg &&
                         (x_ext > mlr_pkg::ext_t'(0));
            minor_wrap = minor_up && (line_cur.cur_x == mlr_pkg::COORD_MAX);
            err_step   = dx2;
            if (minor_up)
            begin
                err_step = err_step - dy2;
                line_next.cur_x = line_cur.cur_x + mlr_pkg::coord_t'(1);
            end
            else if (minor_down)
            begin
                err_step = err_step + dy2;
                line_next.cur_x = line_cur.cur_x - mlr_pkg::coord_t'(1);
            end
            // A minor coordinate that wraps past the top of its range moves
            // the implicit function by a whole coordinate period.
            if (minor_wrap)
            begin
                err_step = err_step +
                           (mlr_pkg::err_t'(line_cur.dy) <<< (mlr_pkg::COORD_BITS + 1));
            end
            line_next.cur_y = line_cur.cur_y + mlr_pkg::coord_t'(1);
        end
        else
        begin
            minor_up   = (line_cur.dy > mlr_pkg::diff_t'(0)) && err_neg &&
                         (y_ext < h_ext - mlr_pkg::ext_t'(1));
            minor_down = (line_cur.dy < mlr_pkg::diff_t'(0)) && err_pos &&
                         (y_ext > mlr_pkg::ext_t'(0));
            minor_wrap = minor_up && (line_cur.cur_y == mlr_pkg::COORD_MAX);
            err_step   = -dy2;
            if (minor_up)
            begin
                err_step = err_step + dx2;
                line_next.cur_y = line_cur.cur_y + mlr_pkg::coord_t'(1);
            end
            else if (minor_down)
            begin
                err_step = err_step - dx2;
                line_next.cur_y = line_cur.cur_y - mlr_pkg::coord_t'(1);
            end
            if (minor_wrap)
            begin
                err_step = err_step -
                           (mlr_pkg::err_t'(line_cur.dx) <<< (mlr_pkg::COORD_BITS + 1));
            end
            line_next.cur_x = line_cur.cur_x + mlr_pkg::coord_t'(1);
        end
        line_next.err = line_cur.err + err_step;
    end

endmodule

FILE: design/midpoint_line_rasterizer.sv
// Midpoint line rasterizer, top level: configuration registers, line state and the
// pixel output register. Uses mlr_pkg, the mlr interfaces, mlr_load_unit, mlr_step_unit.
// A step beat on an active line gives its pixel beat in the next cycle; a load
// beat gives no pixel. One beat is taken every cycle while the output register
// is empty or being drained, so throughput is one pixel per clock.
// Reset leaves no line active, no pixel pending, and the image size 640 x 480.
module midpoint_line_rasterizer (
    input  logic          clk,
    input  logic          rst_n,
    mlr_line_if.sink      line_in,
    mlr_pixel_if.source   pixel_out,
    mlr_cfg_if.sink       cfg
);

    mlr_pkg::size_t       width_reg;
    mlr_pkg::size_t       width_next;
    mlr_pkg::size_t       height_reg;
    mlr_pkg::size_t       height_next;
    mlr_pkg::line_state_t line_reg;
    mlr_pkg::line_state_t line_next;
    mlr_pkg::line_state_t line_init;
    mlr_pkg::line_state_t line_stepped;
    mlr_pkg::pixel_t      pixel_reg;
    mlr_pkg::pixel_t      pixel_next;
    mlr_pkg::pixel_t      pixel_cur;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 in_accept;
    logic                 step_fire;

    mlr_load_unit u_load (
        .start_x   (line_in.start_x),
        .start_y   (line_in.start_y),
        .end_x     (line_in.end_x),
        .end_y     (line_in.end_y),
        .pen_color (line_in.pen_color),
        .line_init (line_init)
    );

    mlr_step_unit u_step (
        .line_cur     (line_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .line_next    (line_stepped),
        .pixel        (pixel_cur)
    );

    assign cfg.ready     = 1'b1;
    assign line_in.ready = !out_valid_reg || pixel_out.ready;
    assign in_accept     = line_in.valid && line_in.ready;
    assign step_fire     = in_accept && (line_in.mode == mlr_pkg::MODE_STEP) && line_reg.active;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                mlr_pkg::CFG_IMAGE_WIDTH:  width_next  = cfg.data;
                mlr_pkg::CFG_IMAGE_HEIGHT: height_next = cfg.data;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        line_next      = line_reg;
        pixel_next     = pixel_reg;
        out_valid_next = out_valid_reg && !pixel_out.ready;
        if (in_accept && (line_in.mode == mlr_pkg::MODE_LOAD))
        begin
            line_next = line_init;
        end
        else if (step_fire)
        begin
            line_next      = line_stepped;
            pixel_next     = pixel_cur;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= mlr_pkg::WIDTH_RESET;
            height_reg    <= mlr_pkg::HEIGHT_RESET;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.pixel_x     = pixel_reg.x;
    assign pixel_out.pixel_y     = pixel_reg.y;
    assign pixel_out.visible     = pixel_reg.visible;
    assign pixel_out.pixel_color = pixel_reg.color;
    assign pixel_out.last_pixel  = pixel_reg.last;

    a_step_gives_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> pixel_out.valid)
        else $error("Step on an active line did not produce a pixel beat.");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && pixel_cur.last) |=> !line_reg.active)
        else $error("Line stayed active after its last pixel.");

    a_major_within_end: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg.active |->
            (line_reg.steep ? (line_reg.cur_y <= line_reg.final_major)
                            : (line_reg.cur_x <= line_reg.final_major)))
        else $error("Major coordinate ran past the end point.");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pixel_out.ready) |-> !line_in.ready)
        else $error("Input taken while a pixel beat is stalled.");

endmodule
